FILE: src/atfe_pkg.sv
// ============================================================================
// atfe_pkg
// Shared types and constants for the ANSI truecolor frame encoder: cell and
// output item layouts, the command passed from front to back, and codes.
// ============================================================================
package atfe_pkg;

    // One input cell: glyph and 24-bit foreground and background colors.
    typedef struct packed {
        logic [7:0] glyph;
        logic [7:0] fg_red;
        logic [7:0] fg_green;
        logic [7:0] fg_blue;
        logic [7:0] bg_red;
        logic [7:0] bg_green;
        logic [7:0] bg_blue;
    } cell_t;

    // One output item: a byte of the terminal stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_t;

    // Escape sequence segments, in emission order.
    localparam int unsigned SegCount = 7;
    typedef logic [2:0] seg_t;
    typedef logic [SegCount-1:0] seg_mask_t;

    localparam seg_t SegPrefix  = 3'd0;
    localparam seg_t SegNewline = 3'd1;
    localparam seg_t SegFgSgr   = 3'd2;
    localparam seg_t SegBgSgr   = 3'd3;
    localparam seg_t SegBgShort = 3'd4;
    localparam seg_t SegGlyph   = 3'd5;
    localparam seg_t SegReset   = 3'd6;

    // Work for one cell, as classified by the front.
    typedef struct packed {
        logic [7:0]  glyph;
        logic [23:0] fg;
        logic [23:0] bg;
        seg_mask_t   segs;
    } cmd_t;

    // Configuration register indexes.
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t RegImageWidth   = 2'd0;
    localparam cfg_idx_t RegImageHeight  = 2'd1;
    localparam cfg_idx_t RegTerminalCols = 2'd2;
    localparam cfg_idx_t RegTerminalRows = 2'd3;

    localparam int unsigned CfgWidth = 11;

    // Largest image side; larger settings are clamped to it.
    localparam logic [10:0] MaxSide = 11'd1024;

    // Depth of the command queue between front and back.
    localparam int unsigned QueueDepth = 4;

    localparam logic [7:0] AsciiSpace = 8'h20;

endpackage

FILE: src/atfe_front.sv
// ============================================================================
// atfe_front
// Accepts cells, holds the configuration registers and the frame position,
// tracks the last colors sent, and turns each cell into a segment command.
// ============================================================================
module atfe_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  atfe_pkg::cfg_idx_t                 cfg_index,
    input  logic [atfe_pkg::CfgWidth-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  atfe_pkg::cell_t                    in_data,
    input  logic                               q_full,
    output logic                               q_push,
    output atfe_pkg::cmd_t                     q_cmd
);

    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [9:0]  terminal_cols_reg;
    logic [9:0]  terminal_rows_reg;
    logic [23:0] last_fg_reg;
    logic [23:0] last_fg_next;
    logic [23:0] last_bg_reg;
    logic [23:0] last_bg_next;
    logic [9:0]  col_reg;
    logic [9:0]  col_next;
    logic [9:0]  row_reg;
    logic [9:0]  row_next;

    logic        accept;
    logic [10:0] width_eff;
    logic [10:0] height_eff;
    logic        row_end;
    logic        frame_end;
    logic        row_shown;
    logic [23:0] fg;
    logic [23:0] bg;
    atfe_pkg::seg_mask_t segs;

    assign fg = {in_data.fg_red, in_data.fg_green, in_data.fg_blue};
    assign bg = {in_data.bg_red, in_data.bg_green, in_data.bg_blue};

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Clamp image sides to the range one to MaxSide.
    always_comb
    begin
        if (image_width_reg == 11'd0)
            width_eff = 11'd1;
        else if (image_width_reg > atfe_pkg::MaxSide)
            width_eff = atfe_pkg::MaxSide;
        else
            width_eff = image_width_reg;

        if (image_height_reg == 11'd0)
            height_eff = 11'd1;
        else if (image_height_reg > atfe_pkg::MaxSide)
            height_eff = atfe_pkg::MaxSide;
        else
            height_eff = image_height_reg;
    end

    assign row_end   = ({1'b0, col_reg} + 11'd1) >= width_eff;
    assign frame_end = ({1'b0, row_reg} + 11'd1) >= height_eff;
    assign row_shown = row_reg < terminal_rows_reg;

    // Classify the cell into segments and work out the tracked colors.
    always_comb
    begin
        segs         = '0;
        last_fg_next = last_fg_reg;
        last_bg_next = last_bg_reg;

        segs[atfe_pkg::SegPrefix] = (col_reg == 10'd0) && (row_reg == 10'd0);

        if (row_shown)
        begin
            if (col_reg == 10'd0)
            begin
                segs[atfe_pkg::SegNewline] = (row_reg != 10'd0);
                segs[atfe_pkg::SegFgSgr]   = 1'b1;
                segs[atfe_pkg::SegBgSgr]   = 1'b1;
                segs[atfe_pkg::SegGlyph]   = 1'b1;
                last_fg_next               = fg;
                last_bg_next               = bg;
            end
            else if (col_reg < terminal_cols_reg)
            begin
                if ((in_data.glyph != atfe_pkg::AsciiSpace) && (fg != last_fg_reg))
                begin
                    segs[atfe_pkg::SegFgSgr] = 1'b1;
                    last_fg_next             = fg;
                end
                if (bg != last_bg_reg)
                begin
                    segs[atfe_pkg::SegBgSgr]   = (bg != 24'd0);
                    segs[atfe_pkg::SegBgShort] = (bg == 24'd0);
                    last_bg_next               = bg;
                end
                segs[atfe_pkg::SegGlyph] = 1'b1;
            end
            segs[atfe_pkg::SegReset] = row_end;
        end
    end

    // Advance the raster position.
    always_comb
    begin
        if (row_end)
        begin
            col_next = 10'd0;
            row_next = frame_end ? 10'd0 : row_reg + 10'd1;
        end
        else
        begin
            col_next = col_reg + 10'd1;
            row_next = row_reg;
        end
    end

    assign q_push = accept && (segs != '0);
    assign q_cmd  = {in_data.glyph, fg, bg, segs};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 11'd80;
            image_height_reg  <= 11'd24;
            terminal_cols_reg <= 10'd80;
            terminal_rows_reg <= 10'd24;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                atfe_pkg::RegImageWidth:   image_width_reg   <= cfg_data;
                atfe_pkg::RegImageHeight:  image_height_reg  <= cfg_data;
                atfe_pkg::RegTerminalCols: terminal_cols_reg <= cfg_data[9:0];
                atfe_pkg::RegTerminalRows: terminal_rows_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Frame position and last colors sent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fg_reg <= '0;
            last_bg_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else if (accept)
        begin
            last_fg_reg <= last_fg_next;
            last_bg_reg <= last_bg_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

FILE: src/atfe_queue.sv
// ============================================================================
// atfe_queue
// Small command queue that decouples the cell front from the byte back.
// ============================================================================
module atfe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  atfe_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output atfe_pkg::cmd_t  head_cmd
);

    localparam int unsigned PtrWidth = $clog2(atfe_pkg::QueueDepth);

    atfe_pkg::cmd_t      store_reg [atfe_pkg::QueueDepth];
    logic [PtrWidth-1:0] wr_ptr_reg;
    logic [PtrWidth-1:0] rd_ptr_reg;
    logic [PtrWidth:0]   count_reg;
    logic [PtrWidth:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == (PtrWidth+1)'(atfe_pkg::QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = store_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    // Pointers stay consistent with the fill count.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || full |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

endmodule

FILE: src/atfe_back.sv
// ============================================================================
// atfe_back
// Walks each command's segments one byte per cycle while out_ready does not stall
// the output, and drives the output item register.
// ============================================================================
module atfe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  atfe_pkg::cmd_t  head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output atfe_pkg::out_t  out_data
);

    // Length in bytes of each segment.
    function automatic logic [4:0] seg_len(atfe_pkg::seg_t seg);
        logic [4:0] len;
        begin
            unique case (seg)
                atfe_pkg::SegPrefix:  len = 5'd11;
                atfe_pkg::SegNewline: len = 5'd1;
                atfe_pkg::SegFgSgr:   len = 5'd19;
                atfe_pkg::SegBgSgr:   len = 5'd19;
                atfe_pkg::SegBgShort: len = 5'd7;
                atfe_pkg::SegGlyph:   len = 5'd1;
                atfe_pkg::SegReset:   len = 5'd4;
                default:              len = 5'd1;
            endcase
            return len;
        end
    endfunction

    // One ASCII decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones.
    function automatic logic [7:0] dec_char(logic [7:0] v, logic [1:0] pos);
        logic [1:0]  hund;
        logic [7:0]  hund_val;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [3:0]  ones;
        logic [3:0]  dig;
        begin
            if (v >= 8'd200)
            begin
                hund     = 2'd2;
                hund_val = 8'd200;
            end
            else if (v >= 8'd100)
            begin
                hund     = 2'd1;
                hund_val = 8'd100;
            end
            else
            begin
                hund     = 2'd0;
                hund_val = 8'd0;
            end
            rem  = 7'(v - hund_val);
            // Multiply by the reciprocal of ten; exact for values below 100.
            prod = 15'(rem) * 15'd205;
            tens = prod[14:11];
            ones = 4'(rem - 7'(tens) * 7'd10);
            case (pos)
                2'd0:    dig = {2'b00, hund};
                2'd1:    dig = tens;
                default: dig = ones;
            endcase
            return 8'h30 + {4'h0, dig};
        end
    endfunction

    // Byte of a full SGR color code ESC[L8;2;RRR;GGG;BBBm.
    function automatic logic [7:0] sgr_byte(logic [7:0] lead, logic [23:0] rgb,
                                            logic [4:0] idx);
        logic [7:0] b;
        begin
            case (idx) inside
                5'd0:                b = 8'h1B;
                5'd1:                b = "[";
                5'd2:                b = lead;
                5'd3:                b = "8";
                5'd5:                b = "2";
                5'd4, 5'd6, 5'd10, 5'd14: b = ";";
                5'd7:                b = dec_char(rgb[23:16], 2'd0);
                5'd8:                b = dec_char(rgb[23:16], 2'd1);
                5'd9:                b = dec_char(rgb[23:16], 2'd2);
                5'd11:               b = dec_char(rgb[15:8], 2'd0);
                5'd12:               b = dec_char(rgb[15:8], 2'd1);
                5'd13:               b = dec_char(rgb[15:8], 2'd2);
                5'd15:               b = dec_char(rgb[7:0], 2'd0);
                5'd16:               b = dec_char(rgb[7:0], 2'd1);
                5'd17:               b = dec_char(rgb[7:0], 2'd2);
                default:             b = "m";
            endcase
            return b;
        end
    endfunction

    logic                cur_valid_reg;
    logic                cur_valid_next;
    atfe_pkg::cmd_t      cur_cmd_reg;
    atfe_pkg::cmd_t      cur_cmd_next;
    atfe_pkg::seg_mask_t mask_reg;
    atfe_pkg::seg_mask_t mask_next;
    logic [4:0]          idx_reg;
    logic [4:0]          idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    atfe_pkg::out_t      out_data_reg;
    atfe_pkg::out_t      out_data_next;

    atfe_pkg::seg_t      seg;
    atfe_pkg::seg_mask_t seg_bit;
    atfe_pkg::seg_mask_t mask_rest;
    logic                seg_done;
    logic                cmd_done;
    logic                advance;
    logic [7:0]          cur_byte;

    // Current segment is the lowest pending one.
    always_comb
    begin
        seg = atfe_pkg::SegReset;
        for (int i = atfe_pkg::SegCount - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                seg = 3'(i);
        end
    end

    assign seg_bit   = atfe_pkg::seg_mask_t'(1) << seg;
    assign mask_rest = mask_reg & ~seg_bit;
    assign seg_done  = (idx_reg == seg_len(seg) - 5'd1);
    assign cmd_done  = seg_done && (mask_rest == '0);
    assign advance   = !out_valid_reg || out_ready;

    // Byte generator for the current segment position.
    always_comb
    begin
        unique case (seg)
            atfe_pkg::SegPrefix:
            begin
                case (idx_reg)
                    5'd0, 5'd3, 5'd7: cur_byte = 8'h1B;
                    5'd1, 5'd4, 5'd8: cur_byte = "[";
                    5'd2:             cur_byte = "H";
                    5'd5:             cur_byte = "3";
                    5'd9:             cur_byte = "2";
                    default:          cur_byte = "J";
                endcase
            end
            atfe_pkg::SegNewline: cur_byte = 8'h0A;
            atfe_pkg::SegFgSgr:   cur_byte = sgr_byte("3", cur_cmd_reg.fg, idx_reg);
            atfe_pkg::SegBgSgr:   cur_byte = sgr_byte("4", cur_cmd_reg.bg, idx_reg);
            atfe_pkg::SegBgShort:
            begin
                case (idx_reg)
                    5'd0:    cur_byte = 8'h1B;
                    5'd1:    cur_byte = "[";
                    5'd2:    cur_byte = "4";
                    5'd3:    cur_byte = "8";
                    5'd4:    cur_byte = ";";
                    5'd5:    cur_byte = "2";
                    default: cur_byte = "m";
                endcase
            end
            atfe_pkg::SegGlyph:   cur_byte = cur_cmd_reg.glyph;
            atfe_pkg::SegReset:
            begin
                case (idx_reg)
                    5'd0:    cur_byte = 8'h1B;
                    5'd1:    cur_byte = "[";
                    5'd2:    cur_byte = "0";
                    default: cur_byte = "m";
                endcase
            end
            default:              cur_byte = cur_cmd_reg.glyph;
        endcase
    end

    // Take the next command when idle or when the current one finishes.
    assign pop = head_valid && (!cur_valid_reg || (advance && cmd_done));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_cmd_next   = cur_cmd_reg;
        mask_next      = mask_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (advance)
        begin
            out_valid_next          = cur_valid_reg;
            out_data_next.out_byte  = cur_byte;
            out_data_next.last_byte = cmd_done;
            if (cur_valid_reg)
            begin
                if (seg_done)
                begin
                    mask_next = mask_rest;
                    idx_next  = 5'd0;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                end
                if (cmd_done)
                    cur_valid_next = 1'b0;
            end
        end

        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_cmd_next   = head_cmd;
            mask_next      = head_cmd.segs;
            idx_next       = 5'd0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_cmd_reg  <= cur_cmd_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A live command always has a segment left to send.
    a_live_has_seg: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> mask_reg != '0)
        else $error("active command with no pending segment");

    // The byte position stays inside the current segment.
    a_idx_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg < seg_len(seg))
        else $error("byte position past end of segment");

endmodule

FILE: src/ansi_truecolor_frame_encoder_unit.sv
// ============================================================================
// ansi_truecolor_frame_encoder_unit
// Turns a raster frame of colored character cells into an ANSI 24-bit color
// terminal byte stream, one byte per output item.
// ============================================================================
// Path: queue entry, current-command register, then the output register.
// Throughput: one byte per cycle unless out_ready stalls; a cell gives up to 54
//   bytes. Cells with no bytes need no queue entry; a four-entry command queue
//   lets the input run ahead.
// Reset: configuration returns to 80x24 image and terminal, colors and position
//   clear to zero, and the queue and output register empty.
module ansi_truecolor_frame_encoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  atfe_pkg::cfg_idx_t            cfg_index,
    input  logic [atfe_pkg::CfgWidth-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  atfe_pkg::cell_t               in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output atfe_pkg::out_t                out_data
);

    logic           q_full;
    logic           q_push;
    atfe_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic           q_head_valid;
    atfe_pkg::cmd_t q_head_cmd;

    // Cell classification and frame tracking.
    atfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Command queue.
    atfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Byte sequencer and output register.
    atfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

FILE: sim/terminal_stream_checker.sv
// ============================================================================
// terminal_stream_checker
// Watches the configuration port and both item channels of the ANSI truecolor
// frame encoder. It keeps its own copy of the encoder state, works out the
// byte stream that each accepted cell must produce, and compares every
// accepted output item with the oldest byte still expected.
// ============================================================================
module terminal_stream_checker
    import atfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  cfg_idx_t             cfg_index,
    input  logic [CfgWidth-1:0]  cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  cell_t                in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_t                 out_data,
    output int unsigned          mismatch_count,
    output int unsigned          bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Characters used to build escape sequences.
    localparam logic [7:0] ChEsc      = 8'h1B;
    localparam logic [7:0] ChLBracket = 8'h5B;
    localparam logic [7:0] ChZero     = 8'h30;
    localparam logic [7:0] ChTwo      = 8'h32;
    localparam logic [7:0] ChThree    = 8'h33;
    localparam logic [7:0] ChFour     = 8'h34;
    localparam logic [7:0] ChEight    = 8'h38;
    localparam logic [7:0] ChSemi     = 8'h3B;
    localparam logic [7:0] ChLowerM   = 8'h6D;
    localparam logic [7:0] ChUpperH   = 8'h48;
    localparam logic [7:0] ChUpperJ   = 8'h4A;
    localparam logic [7:0] ChNewline  = 8'h0A;

    // Mirrored configuration.
    logic [10:0] img_width;
    logic [10:0] img_height;
    logic [9:0]  term_cols;
    logic [9:0]  term_rows;

    // Mirrored encoder state.
    logic [23:0] sent_fg;
    logic [23:0] sent_bg;
    logic [9:0]  col_pos;
    logic [9:0]  row_pos;

    // Bytes of the cell being encoded, and all bytes still owed by the block.
    logic [7:0]  cell_bytes[$];
    out_t        expected_bytes[$];

    initial mismatch_count = 0;
    initial bytes_pending = 0;

    // Zero counts as one and anything above the largest side is clamped.
    function automatic int unsigned side_of(input logic [10:0] v);
        if (v == 11'd0)
            return 1;
        if (v > MaxSide)
            return int'(MaxSide);
        return int'(v);
    endfunction

    task automatic put_char(input logic [7:0] b);
        cell_bytes.insert(cell_bytes.size(), b);
    endtask

    // Color components are always written as three decimal digits.
    task automatic put_dec3(input logic [7:0] v);
        put_char(ChZero + v / 8'd100);
        put_char(ChZero + (v % 8'd100) / 8'd10);
        put_char(ChZero + v % 8'd10);
    endtask

    // Full SGR color code; lead selects foreground (3) or background (4).
    task automatic put_sgr(input logic [7:0] lead, input logic [23:0] rgb);
        put_char(ChEsc);
        put_char(ChLBracket);
        put_char(lead);
        put_char(ChEight);
        put_char(ChSemi);
        put_char(ChTwo);
        put_char(ChSemi);
        put_dec3(rgb[23:16]);
        put_char(ChSemi);
        put_dec3(rgb[15:8]);
        put_char(ChSemi);
        put_dec3(rgb[7:0]);
        put_char(ChLowerM);
    endtask

    // Work out the bytes one cell causes and advance the raster position.
    task automatic encode_cell(input cell_t c);
        logic [23:0] fg;
        logic [23:0] bg;
        logic        row_end;
        logic        frame_end;
        logic        row_shown;
        out_t        item;
        fg = {c.fg_red, c.fg_green, c.fg_blue};
        bg = {c.bg_red, c.bg_green, c.bg_blue};
        row_end = int'(col_pos) + 1 >= int'(side_of(img_width));
        frame_end = int'(row_pos) + 1 >= int'(side_of(img_height));
        row_shown = row_pos < term_rows;

        // Home and clear at the start of every frame, shown or not.
        if (col_pos == 10'd0 && row_pos == 10'd0)
        begin
            put_char(ChEsc);
            put_char(ChLBracket);
            put_char(ChUpperH);
            put_char(ChEsc);
            put_char(ChLBracket);
            put_char(ChThree);
            put_char(ChUpperJ);
            put_char(ChEsc);
            put_char(ChLBracket);
            put_char(ChTwo);
            put_char(ChUpperJ);
        end

        if (row_shown)
        begin
            if (col_pos == 10'd0)
            begin
                if (row_pos != 10'd0)
                    put_char(ChNewline);
                sent_fg = fg;
                sent_bg = bg;
                put_sgr(ChThree, fg);
                put_sgr(ChFour, bg);
                put_char(c.glyph);
            end
            else if (col_pos < term_cols)
            begin
                // A space shows no foreground, so its color is not sent.
                if (c.glyph != AsciiSpace && fg != sent_fg)
                begin
                    sent_fg = fg;
                    put_sgr(ChThree, fg);
                end
                if (bg != sent_bg)
                begin
                    sent_bg = bg;
                    if (bg != 24'd0)
                        put_sgr(ChFour, bg);
                    else
                    begin
                        put_char(ChEsc);
                        put_char(ChLBracket);
                        put_char(ChFour);
                        put_char(ChEight);
                        put_char(ChSemi);
                        put_char(ChTwo);
                        put_char(ChLowerM);
                    end
                end
                put_char(c.glyph);
            end
            if (row_end)
            begin
                put_char(ChEsc);
                put_char(ChLBracket);
                put_char(ChZero);
                put_char(ChLowerM);
            end
        end

        if (row_end)
        begin
            col_pos = 10'd0;
            row_pos = frame_end ? 10'd0 : row_pos + 10'd1;
        end
        else
            col_pos = col_pos + 10'd1;

        foreach (cell_bytes[i])
        begin
            item.out_byte = cell_bytes[i];
            item.last_byte = (i == cell_bytes.size() - 1);
            expected_bytes.insert(expected_bytes.size(), item);
        end
        cell_bytes.delete();
    endtask

    task automatic flag_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s mismatch: expected 0x%02h, got 0x%02h",
                     $time, field, want, got);
    endtask

    // Track configuration writes, predict on accepted cells, check output items.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            img_width = 11'd80;
            img_height = 11'd24;
            term_cols = 10'd80;
            term_rows = 10'd24;
            sent_fg = 24'd0;
            sent_bg = 24'd0;
            col_pos = 10'd0;
            row_pos = 10'd0;
            cell_bytes.delete();
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    RegImageWidth:   img_width = cfg_data;
                    RegImageHeight:  img_height = cfg_data;
                    RegTerminalCols: term_cols = cfg_data[9:0];
                    RegTerminalRows: term_rows = cfg_data[9:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                encode_cell(in_data);

            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected output item: byte 0x%02h, last %0b",
                                 $time, out_data.out_byte, out_data.last_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        flag_field("out_byte", want.out_byte, out_data.out_byte);
                    if (out_data.last_byte !== want.last_byte)
                        flag_field("last_byte", {7'd0, want.last_byte},
                                   {7'd0, out_data.last_byte});
                end
            end
        end
        bytes_pending = expected_bytes.size();
    end

endmodule

FILE: sim/ansi_truecolor_frame_encoder_unit_test.sv
// ============================================================================
// ansi_truecolor_frame_encoder_unit_test
// Drives cells into the ANSI truecolor frame encoder under a series of image
// and terminal sizes: a directed set of cells for the corner cases, then
// random cells with random idling on both channels. A checker beside the
// block predicts and compares the byte stream; this module gives the verdict.
// ============================================================================
module ansi_truecolor_frame_encoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atfe_pkg::*;

    localparam int unsigned CycleLimit    = 400000;
    localparam int unsigned SettleCycles  = 12;
    localparam int unsigned RandomPhases  = 8;
    localparam int unsigned CellsPerPhase = 40;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write;
    cfg_idx_t            cfg_index;
    logic [CfgWidth-1:0] cfg_data;
    logic                in_valid;
    logic                in_ready;
    cell_t               in_data;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_t                out_data;

    int unsigned         mismatch_count;
    int unsigned         bytes_pending;
    int unsigned         cycle_count = 0;
    logic                quiet = 1'b0;
    logic [23:0]         recent_fg = 24'd0;
    logic [23:0]         recent_bg = 24'd0;

    always #6 clk = ~clk;

    ansi_truecolor_frame_encoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    terminal_stream_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending)
    );

    // The byte receiver stalls now and then, except during a quiet stretch.
    always @(posedge clk)
    begin
        out_ready <= rst_n && (quiet || $urandom_range(99) >= 6);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic cell_t make_cell(input logic [7:0] g, input logic [23:0] fg,
                                        input logic [23:0] bg);
        return {g, fg, bg};
    endfunction

    // Colors repeat often so that the unchanged-color paths are taken.
    function automatic logic [23:0] pick_color(input logic [23:0] prev);
        case ($urandom_range(9))
            0, 1, 2: return prev;
            3:       return 24'd0;
            4:       return 24'hFFFFFF;
            5:       return {8'($urandom_range(255)), prev[15:0]};
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic cell_t random_cell();
        logic [7:0] g;
        case ($urandom_range(9))
            0, 1:    g = AsciiSpace;
            2:       g = 8'h00;
            3:       g = 8'hFF;
            default: g = 8'($urandom_range(255));
        endcase
        recent_fg = pick_color(recent_fg);
        recent_bg = pick_color(recent_bg);
        return {g, recent_fg, recent_bg};
    endfunction

    // Image sides: mostly small, sometimes zero, the largest, or beyond it.
    function automatic logic [10:0] pick_side();
        case ($urandom_range(11))
            0:       return 11'd0;
            1:       return 11'h7FF;
            2:       return MaxSide;
            3:       return 11'($urandom_range(7, 40));
            default: return 11'($urandom_range(1, 5));
        endcase
    endfunction

    // Terminal sizes; the top data bit is ignored by these registers.
    function automatic logic [10:0] pick_span();
        case ($urandom_range(9))
            0:       return 11'd0;
            1:       return 11'h7FF;
            2:       return 11'd1023;
            default: return 11'($urandom_range(1, 6));
        endcase
    endfunction

    // Offer one cell and hold it until the block takes it.
    task automatic send_cell(input cell_t c);
        if (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Wait until every expected byte has come out, then let cells that
    // produce no bytes drain from the block.
    task automatic wait_drained();
        @(posedge clk);
        while (bytes_pending != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgWidth-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
    endtask

    task automatic configure(input logic [10:0] w, input logic [10:0] h,
                             input logic [10:0] c, input logic [10:0] r);
        in_valid <= 1'b0;
        wait_drained();
        write_reg(RegImageWidth, w);
        write_reg(RegImageHeight, h);
        write_reg(RegTerminalCols, c);
        write_reg(RegTerminalRows, r);
        cfg_write <= 1'b0;
    endtask

    task automatic run_directed();
        // Reset sizes: a full first cell, then both colors changing.
        send_cell(make_cell(8'h41, 24'hFFFFFF, 24'h000000));
        send_cell(make_cell(8'hFF, 24'h000000, 24'hFFFFFF));

        // Shrinking mid-frame ends the row at once. The third column is past
        // the terminal, and the second row is below it.
        configure(11'd3, 11'd2, 11'd2, 11'd1);
        send_cell(make_cell(8'h78, 24'h010203, 24'h040506));
        send_cell(make_cell(8'h41, 24'h111111, 24'h222222));
        send_cell(make_cell(8'h42, 24'h333333, 24'h444444));
        send_cell(make_cell(8'h43, 24'h555555, 24'h666666));
        send_cell(make_cell(8'h7E, 24'h123456, 24'hABCDEF));
        // A space hides its foreground change; a black background is short.
        send_cell(make_cell(AsciiSpace, 24'hFEDCBA, 24'h000000));
        send_cell(make_cell(8'h00, 24'h00FF00, 24'hFF00FF));
        send_cell(make_cell(8'h44, 24'h0000FF, 24'h00FF00));
        send_cell(make_cell(8'h45, 24'hFF0000, 24'h0000FF));
        send_cell(make_cell(8'h46, 24'h808080, 24'h7F7F7F));

        // Zero sides act as one and no terminal row is shown: prefix only.
        configure(11'd0, 11'd0, 11'd0, 11'd0);
        send_cell(make_cell(8'h47, 24'h999999, 24'h999999));
        send_cell(make_cell(8'h48, 24'hFFFFFF, 24'hFFFFFF));

        // No terminal columns: column 0 still shows, column 1 is dropped.
        configure(11'd2, 11'd1, 11'd0, 11'd1);
        send_cell(make_cell(8'h49, 24'h0A0B0C, 24'hC8C9FF));
        send_cell(make_cell(8'h4A, 24'hFFFFFF, 24'h000000));
        send_cell(make_cell(8'h4B, 24'h646464, 24'h0A0A0A));
        send_cell(make_cell(8'h4C, 24'h000000, 24'hFFFFFF));

        // Oversized image clamps to the largest side; largest terminal.
        configure(11'h7FF, 11'h7FF, 11'h7FF, 11'd1023);
        send_cell(make_cell(8'h4D, 24'hC86432, 24'h09635A));
        send_cell(make_cell(8'h4E, 24'hC86432, 24'h09635A));
        send_cell(make_cell(8'h4F, 24'h010101, 24'hF0F0F0));
        send_cell(make_cell(8'h50, 24'h010101, 24'h000000));
        send_cell(make_cell(AsciiSpace, 24'hABABAB, 24'h000000));

        // One-cell rows: each row closes at once and later rows take a newline.
        configure(11'd1, 11'd3, 11'd1, 11'd2);
        send_cell(make_cell(8'h51, 24'h102030, 24'h405060));
        send_cell(make_cell(8'h52, 24'h708090, 24'hA0B0C0));
    endtask

    task automatic run_random();
        for (int p = 0; p < RandomPhases; p++)
        begin
            configure(pick_side(), pick_side(), pick_span(), pick_span());
            quiet = (p == 0);
            for (int k = 0; k < CellsPerPhase; k++)
            begin
                // Once, hold the sender back until the byte stream is empty.
                if (p == 3 && k == 20)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_cell(random_cell());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = RegImageWidth;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();

        in_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && bytes_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
